FILE: rtl/bmmp_pkg.sv
package bmmp_pkg;

   localparam int ENTRIES = 1024;
   localparam int KEYS    = 32;
   localparam int ADDR_W  = $clog2(ENTRIES);

   localparam int OPC_W   = 3;
   localparam int IDX_W   = 10;
   localparam int KEY_W   = 5;
   localparam int MASK_W  = 32;
   localparam int SPAN_W  = 11;
   localparam int CNT_W   = 8;
   localparam int PC_W    = $clog2(KEYS + 1);

   typedef enum logic [OPC_W-1:0] {
      OP_SET_BIT   = 3'd0,
      OP_CLR_BIT   = 3'd1,
      OP_RD_BIT    = 3'd2,
      OP_ZERO_WORD = 3'd3,
      OP_INIT_CNT  = 3'd4,
      OP_ADD_CNT   = 3'd5,
      OP_RD_CNT    = 3'd6
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_ZERO,
      ST_PASS,
      ST_HOLD
   } state_type;

   // set bits in a 4-bit value
   localparam logic [2:0] NIBBLE_ONES [16] = '{
      3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
      3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
   };

endpackage

FILE: rtl/bmmp_req_if.sv
interface bmmp_req_if;
   import bmmp_pkg::*;

   logic              valid;
   logic              ready;
   logic [OPC_W-1:0]  opcode;
   logic [IDX_W-1:0]  entry_index;
   logic [KEY_W-1:0]  key_number;
   logic              bit_value;
   logic [MASK_W-1:0] key_mask;
   logic [SPAN_W-1:0] span;

   modport source (
      output valid, opcode, entry_index, key_number, bit_value, key_mask, span,
      input  ready
   );

   modport sink (
      input  valid, opcode, entry_index, key_number, bit_value, key_mask, span,
      output ready
   );

endinterface

FILE: rtl/bmmp_rsp_if.sv
interface bmmp_rsp_if;
   import bmmp_pkg::*;

   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] read_value;

   modport source (
      output valid, read_value,
      input  ready
   );

   modport sink (
      input  valid, read_value,
      output ready
   );

endinterface

FILE: rtl/bmmp_ram.sv
module bmmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bmmp_count_unit.sv
module bmmp_count_unit (
   input  logic [bmmp_pkg::KEYS-1:0]  word,
   input  logic [bmmp_pkg::KEYS-1:0]  mask,
   input  logic [bmmp_pkg::CNT_W-1:0] old_count,
   input  logic                       accumulate,
   output logic [bmmp_pkg::CNT_W-1:0] new_count
);
   import bmmp_pkg::*;

   logic [KEYS-1:0] masked;
   logic [PC_W-1:0] ones;

   assign masked = word & mask;

   // sum per-nibble counts
   always_comb begin
      logic [PC_W-1:0] sum;
      sum = '0;
      for (int n = 0; n < KEYS / 4; n++) begin
         sum = sum + PC_W'(NIBBLE_ONES[masked[4*n +: 4]]);
      end
      ones = sum;
   end

   // wrap modulo 256 on accumulate
   assign new_count = accumulate ? CNT_W'(old_count + CNT_W'(ones)) : CNT_W'(ones);

endmodule

FILE: rtl/bit_matrix_masked_popcount.sv
// Channel   Dir  Handshake            Payload
// req_ch    in   valid/ready          opcode, entry_index, key_number, bit_value,
//                                     key_mask, span
// rsp_ch    out  valid/ready          read_value (one per request transaction)
//
// A bit, zero-word or count-read transaction is accepted with the memory read, then
// has one modify/write step, then loads the response register.
// A count pass covers min(span, 1024) entries; the shared popcount unit handles one
// entry per cycle, limited by the single read and write port of each memory. An empty
// span or the unused opcode goes from acceptance straight to loading the response.
// After reset all 1024 key memory entries are cleared one entry per cycle; no
// request is accepted meanwhile. One new request is accepted while a response waits;
// its own response then holds the block until the response register drains.
module bit_matrix_masked_popcount (
   input  logic        clock,
   input  logic        reset,
   bmmp_req_if.sink    req_ch,
   bmmp_rsp_if.source  rsp_ch
);
   import bmmp_pkg::*;

   state_type         state_ff,     state_in;
   opcode_type        op_ff,        op_in;
   logic [ADDR_W-1:0] idx_ff,       idx_in;
   logic              idx_ok_ff,    idx_ok_in;
   logic [KEY_W-1:0]  key_ff,       key_in;
   logic              val_ff,       val_in;
   logic [KEYS-1:0]   mask_ff,      mask_in;
   logic [ADDR_W:0]   len_ff,       len_in;
   logic [ADDR_W:0]   issue_ff,     issue_in;
   logic              pipe_vld_ff,  pipe_vld_in;
   logic [ADDR_W-1:0] pipe_addr_ff, pipe_addr_in;
   logic [ADDR_W-1:0] clr_ff,       clr_in;
   logic [CNT_W-1:0]  result_ff,    result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_value_ff, rsp_value_in;

   logic              accept;
   logic              key_ok;
   logic [KEYS-1:0]   bit_sel;

   logic              key_we;
   logic [ADDR_W-1:0] key_waddr;
   logic [KEYS-1:0]   key_wdata;
   logic              key_re;
   logic [ADDR_W-1:0] key_raddr;
   logic [KEYS-1:0]   key_rdata;

   logic              cnt_we;
   logic [CNT_W-1:0]  cnt_wdata;
   logic              cnt_re;
   logic [ADDR_W-1:0] cnt_raddr;
   logic [CNT_W-1:0]  cnt_rdata;

   bmmp_ram #(.WIDTH(KEYS), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_en   (key_re),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   bmmp_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (pipe_addr_ff),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   bmmp_count_unit u_count_unit (
      .word       (key_rdata),
      .mask       (mask_ff),
      .old_count  (cnt_rdata),
      .accumulate (op_ff == OP_ADD_CNT),
      .new_count  (cnt_wdata)
   );

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign accept            = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;

   assign key_ok  = (32'(key_ff) < KEYS);
   assign bit_sel = key_ok ? (KEYS'(1) << key_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      idx_ok_in    = idx_ok_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      mask_in      = mask_ff;
      len_in       = len_ff;
      issue_in     = issue_ff;
      pipe_vld_in  = 1'b0;
      pipe_addr_in = pipe_addr_ff;
      clr_in       = clr_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;

      key_we    = 1'b0;
      key_waddr = idx_ff;
      key_wdata = '0;
      key_re    = 1'b0;
      key_raddr = ADDR_W'(req_ch.entry_index);
      cnt_we    = 1'b0;
      cnt_re    = 1'b0;
      cnt_raddr = ADDR_W'(req_ch.entry_index);

      case (state_ff)
         ST_CLEAR: begin
            key_we    = 1'b1;
            key_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               op_in     = opcode_type'(req_ch.opcode);
               idx_in    = ADDR_W'(req_ch.entry_index);
               idx_ok_in = (32'(req_ch.entry_index) < ENTRIES);
               key_in    = req_ch.key_number;
               val_in    = req_ch.bit_value;
               mask_in   = KEYS'(req_ch.key_mask);
               len_in    = (32'(req_ch.span) > ENTRIES) ? (ADDR_W + 1)'(ENTRIES)
                                                       : (ADDR_W + 1)'(req_ch.span);
               issue_in  = '0;
               result_in = '0;
               // fetch the addressed word and count for the modify cycle
               key_re    = 1'b1;
               cnt_re    = 1'b1;
               case (opcode_type'(req_ch.opcode))
                  OP_SET_BIT, OP_CLR_BIT, OP_RD_BIT, OP_RD_CNT: state_in = ST_MODIFY;
                  OP_ZERO_WORD:                               state_in = ST_ZERO;
                  OP_INIT_CNT, OP_ADD_CNT: begin
                     state_in = (req_ch.span == '0) ? ST_HOLD : ST_PASS;
                  end
                  default:                                    state_in = ST_HOLD;
               endcase
            end
         end

         ST_MODIFY: begin
            case (op_ff)
               OP_SET_BIT, OP_CLR_BIT: begin
                  key_we    = idx_ok_ff && key_ok;
                  key_wdata = (op_ff == OP_SET_BIT && val_ff) ? (key_rdata | bit_sel)
                                                              : (key_rdata & ~bit_sel);
               end
               OP_RD_BIT: begin
                  result_in = CNT_W'(idx_ok_ff && ((key_rdata & bit_sel) != '0));
               end
               OP_RD_CNT: begin
                  result_in = idx_ok_ff ? cnt_rdata : '0;
               end
               default: begin
                  result_in = '0;
               end
            endcase
            state_in = ST_HOLD;
         end

         ST_ZERO: begin
            key_we    = idx_ok_ff;
            key_wdata = '0;
            state_in  = ST_HOLD;
         end

         ST_PASS: begin
            // read entry issue_ff while the previous entry's count is written
            cnt_we    = pipe_vld_ff;
            key_raddr = ADDR_W'(issue_ff);
            cnt_raddr = ADDR_W'(issue_ff);
            if (issue_ff < len_ff) begin
               key_re       = 1'b1;
               cnt_re       = 1'b1;
               issue_in     = issue_ff + 1'b1;
               pipe_vld_in  = 1'b1;
               pipe_addr_in = ADDR_W'(issue_ff);
            end else begin
               state_in = ST_HOLD;
            end
         end

         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      idx_ok_ff    <= idx_ok_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      mask_ff      <= mask_in;
      len_ff       <= len_in;
      issue_ff     <= issue_in;
      pipe_addr_ff <= pipe_addr_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   import bmmp_pkg::*;

   // opcode 7 has no operation behind it and must leave everything alone
   localparam logic [OPC_W-1:0] OP_UNUSED = 3'd7;

   localparam int unsigned QUIET_LIMIT  = 20000;
   localparam int unsigned STALL_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef struct packed {
      logic [OPC_W-1:0]  opcode;
      logic [IDX_W-1:0]  entry_index;
      logic [KEY_W-1:0]  key_number;
      logic              bit_value;
      logic [MASK_W-1:0] key_mask;
      logic [SPAN_W-1:0] span;
   } matrix_op_type;

   typedef struct {
      logic [OPC_W-1:0] opcode;
      logic [IDX_W-1:0] entry_index;
      logic [CNT_W-1:0] read_value;
   } pending_read_type;

   logic clock = 1'b0;
   logic reset;

   bmmp_req_if req_ch();
   bmmp_rsp_if rsp_ch();

   bit_matrix_masked_popcount dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the key words and the per-entry counts
   logic [KEYS-1:0]  key_mem   [ENTRIES];
   logic [CNT_W-1:0] count_mem [ENTRIES];
   // counts below this entry have been written by some pass
   int               counted_span = 0;

   pending_read_type pending_reads [$];
   int unsigned      read_mismatches = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;
   int unsigned      stall_requests = 0;
   int unsigned      stall_served = 0;
   int unsigned      stall_left = 0;
   int unsigned      quiet_cycles = 0;

   always #4 clock = ~clock;

   function automatic logic [CNT_W-1:0] count_keys(input logic [KEYS-1:0] word);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int b = 0; b < KEYS; b++) n = n + CNT_W'(word[b]);
      return n;
   endfunction

   // update the shadow state for one transaction and return its read_value
   function automatic logic [CNT_W-1:0] apply_matrix_op(input matrix_op_type op);
      int               len;
      logic [CNT_W-1:0] c;
      logic [CNT_W-1:0] value;
      value = '0;
      case (op.opcode)
         OP_SET_BIT, OP_CLR_BIT: begin
            key_mem[op.entry_index][op.key_number] = (op.opcode == OP_SET_BIT) && op.bit_value;
         end
         OP_RD_BIT: value = CNT_W'(key_mem[op.entry_index][op.key_number]);
         OP_ZERO_WORD: key_mem[op.entry_index] = '0;
         OP_INIT_CNT, OP_ADD_CNT: begin
            len = (int'(op.span) > ENTRIES) ? ENTRIES : int'(op.span);
            for (int e = 0; e < len; e++) begin
               c = count_keys(key_mem[e] & op.key_mask);
               count_mem[e] = (op.opcode == OP_ADD_CNT) ? count_mem[e] + c : c;
            end
            if (len > counted_span) counted_span = len;
         end
         OP_RD_CNT: value = count_mem[op.entry_index];
         default: ;
      endcase
      return value;
   endfunction

   function automatic matrix_op_type make_op(input logic [OPC_W-1:0] opcode,
                                             input int unsigned idx, input int unsigned key,
                                             input int unsigned val,
                                             input logic [MASK_W-1:0] mask,
                                             input int unsigned span);
      matrix_op_type op;
      op.opcode      = opcode;
      op.entry_index = IDX_W'(idx);
      op.key_number  = KEY_W'(key);
      op.bit_value   = 1'(val);
      op.key_mask    = mask;
      op.span        = SPAN_W'(span);
      return op;
   endfunction

   function automatic matrix_op_type rand_matrix_op();
      matrix_op_type op;
      int unsigned   roll;
      // keep most bit traffic on a few entries so their words get dense
      op.entry_index = IDX_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(0, ENTRIES - 1));
      op.key_number  = KEY_W'($urandom_range(0, KEYS - 1));
      op.bit_value   = 1'($urandom_range(0, 1));
      op.key_mask    = ($urandom_range(0, 9) < 3) ? '1 : $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 85)      op.span = SPAN_W'($urandom_range(1, 32));
      else if (roll < 95) op.span = SPAN_W'($urandom_range(0, 128));
      else                op.span = SPAN_W'($urandom_range(0, 2047));
      // init passes are rare so that add passes pile up and wrap
      roll = $urandom_range(0, 999);
      if (roll < 300)      op.opcode = OP_SET_BIT;
      else if (roll < 400) op.opcode = OP_CLR_BIT;
      else if (roll < 540) op.opcode = OP_RD_BIT;
      else if (roll < 590) op.opcode = OP_ZERO_WORD;
      else if (roll < 595) op.opcode = OP_INIT_CNT;
      else if (roll < 745) op.opcode = OP_ADD_CNT;
      else if (roll < 980) op.opcode = OP_RD_CNT;
      else                 op.opcode = OP_UNUSED;
      // read counts only where a pass has written one
      if (op.opcode == OP_RD_CNT) begin
         if (counted_span == 0) begin
            op.opcode = OP_RD_BIT;
         end else if ($urandom_range(0, 3) == 0) begin
            op.entry_index = IDX_W'($urandom_range(0, counted_span - 1));
         end else begin
            op.entry_index = IDX_W'($urandom_range(0, counted_span - 1) % 16);
         end
      end
      return op;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_matrix_op(input matrix_op_type op);
      int unsigned      gap;
      pending_read_type rd;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op.opcode;
      req_ch.entry_index <= op.entry_index;
      req_ch.key_number  <= op.key_number;
      req_ch.bit_value   <= op.bit_value;
      req_ch.key_mask    <= op.key_mask;
      req_ch.span        <= op.span;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      rd.opcode      = op.opcode;
      rd.entry_index = op.entry_index;
      rd.read_value  = apply_matrix_op(op);
      pending_reads  = {pending_reads, rd};
      @(negedge clock);
   endtask

   // drop valid so the last transaction is not offered again, then drain
   task automatic wait_for_reads();
      req_ch.valid <= 1'b0;
      while (pending_reads.size() != 0) @(negedge clock);
   endtask

   task automatic test_bit_access();
      send_matrix_op(make_op(OP_SET_BIT, 0, 0, 1, $urandom, $urandom));
      send_matrix_op(make_op(OP_SET_BIT, ENTRIES - 1, KEYS - 1, 1, $urandom, $urandom));
      send_matrix_op(make_op(OP_SET_BIT, ENTRIES - 1, 0, 1, $urandom, $urandom));
      send_matrix_op(make_op(OP_RD_BIT, 0, 0, 0, $urandom, $urandom));
      send_matrix_op(make_op(OP_RD_BIT, ENTRIES - 1, KEYS - 1, 0, $urandom, $urandom));
      // set with a zero value clears the bit
      send_matrix_op(make_op(OP_SET_BIT, ENTRIES - 1, 0, 0, $urandom, $urandom));
      send_matrix_op(make_op(OP_RD_BIT, ENTRIES - 1, 0, 1, $urandom, $urandom));
      // clear ignores the value field
      send_matrix_op(make_op(OP_CLR_BIT, 0, 0, 1, $urandom, $urandom));
      send_matrix_op(make_op(OP_RD_BIT, 0, 0, 1, $urandom, $urandom));
      send_matrix_op(make_op(OP_SET_BIT, 0, 5, 1, $urandom, $urandom));
      send_matrix_op(make_op(OP_SET_BIT, 2, KEYS - 1, 1, $urandom, $urandom));
      send_matrix_op(make_op(OP_SET_BIT, 2, KEYS - 2, 1, $urandom, $urandom));
      send_matrix_op(make_op(OP_ZERO_WORD, ENTRIES - 1, 3, 1, '1, $urandom));
      send_matrix_op(make_op(OP_RD_BIT, ENTRIES - 1, KEYS - 1, 1, $urandom, $urandom));
      send_matrix_op(make_op(OP_UNUSED, 0, 5, 0, '1, 2047));
      send_matrix_op(make_op(OP_RD_BIT, 0, 5, 0, $urandom, $urandom));
   endtask

   task automatic test_count_passes();
      // span beyond the table saturates and writes every count
      send_matrix_op(make_op(OP_INIT_CNT, 7, 1, 1, '1, 2047));
      send_matrix_op(make_op(OP_RD_CNT, ENTRIES - 1, 0, 0, $urandom, $urandom));
      send_matrix_op(make_op(OP_RD_CNT, 0, 0, 0, $urandom, $urandom));
      send_matrix_op(make_op(OP_RD_CNT, 2, 0, 0, $urandom, $urandom));
      // an empty span must not touch the counts
      send_matrix_op(make_op(OP_INIT_CNT, 0, 0, 0, '0, 0));
      send_matrix_op(make_op(OP_RD_CNT, 0, 0, 0, $urandom, $urandom));
      send_matrix_op(make_op(OP_ADD_CNT, 0, 0, 0, 32'h0000_0020, 3));
      send_matrix_op(make_op(OP_RD_CNT, 0, 0, 0, $urandom, $urandom));
      send_matrix_op(make_op(OP_ADD_CNT, 0, 0, 0, '1, ENTRIES));
      send_matrix_op(make_op(OP_RD_CNT, 2, 0, 0, $urandom, $urandom));
      send_matrix_op(make_op(OP_INIT_CNT, 0, 0, 0, 32'h8000_0000, 1));
      send_matrix_op(make_op(OP_RD_CNT, 0, 0, 0, $urandom, $urandom));
      send_matrix_op(make_op(OP_RD_CNT, 2, 0, 0, $urandom, $urandom));
   endtask

   task automatic test_random_traffic(input int unsigned n);
      repeat (n) send_matrix_op(rand_matrix_op());
   endtask

   // hold the response side off while short operations keep arriving
   task automatic test_output_backpressure();
      matrix_op_type op;
      stall_requests++;
      repeat (40) begin
         op = rand_matrix_op();
         if (op.opcode == OP_INIT_CNT || op.opcode == OP_ADD_CNT) op.opcode = OP_RD_BIT;
         send_matrix_op(op);
      end
      wait_for_reads();
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (stall_served != stall_requests) begin
         rsp_ch.ready <= 1'b0;
         stall_served <= stall_served + 1;
         stall_left   <= STALL_CYCLES;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      pending_read_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_reads.size() == 0) begin
            read_mismatches++;
            if (read_mismatches <= MAX_REPORTS)
               $display("unexpected response transaction: read_value %0d", rsp_ch.read_value);
         end else begin
            want = pending_reads.pop_front();
            if (rsp_ch.read_value !== want.read_value) begin
               read_mismatches++;
               if (read_mismatches <= MAX_REPORTS)
                  $display("read_value mismatch (opcode %0d, entry %0d): expected %0d, got %0d",
                           want.opcode, want.entry_index, want.read_value,
                           rsp_ch.read_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = '0;
      req_ch.entry_index = '0;
      req_ch.key_number  = '0;
      req_ch.bit_value   = 1'b0;
      req_ch.key_mask    = '0;
      req_ch.span        = '0;
      for (int e = 0; e < ENTRIES; e++) begin
         key_mem[e]   = '0;
         count_mem[e] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 81;
      test_bit_access();
      test_count_passes();
      test_random_traffic(450);
      wait_for_reads();

      send_idle_pct = 81;
      recv_idle_pct = 6;
      test_random_traffic(450);
      wait_for_reads();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_output_backpressure();
      test_random_traffic(400);

      wait_for_reads();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (read_mismatches == 0 && pending_reads.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
